### src/chbd_pkg.sv
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types and constants for the chunked body decoder: the byte beat,
// the result beat and the default widths of the internal counters.
// ----------------------------------------------------------------------------
`default_nettype none

package chbd_pkg;

  // default storage widths
  localparam int unsigned SIZE_BITS_DEF   = 32;
  localparam int unsigned LENGTH_BITS_DEF = 48;
  localparam int unsigned COUNT_BITS_DEF  = 32;

  // fixed result field widths
  localparam int unsigned CHUNK_COUNT_W = 32;
  localparam int unsigned BODY_LENGTH_W = 48;

  // character codes
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;

  // one input beat
  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic                     payload_valid;
    logic [7:0]               payload_byte;
    logic                     chunk_last;
    logic                     body_done;
    logic                     message_done;
    logic                     after_end;
    logic                     size_error;
    logic [CHUNK_COUNT_W-1:0] chunk_count;
    logic [BODY_LENGTH_W-1:0] body_length;
  } result_t;

endpackage

`default_nettype wire

### src/chbd_in_stage.sv
// ----------------------------------------------------------------------------
// chbd_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire chbd_pkg::in_beat_t beat_i,
  output logic                    vld_o,
  input  wire logic               take_i,
  output chbd_pkg::in_beat_t      beat_o
);

  logic               vld_q;
  chbd_pkg::in_beat_t beat_q;

  // stage is free when empty or being drained this cycle
  assign in_ready_o = !vld_q || take_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // beat payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign vld_o  = vld_q;
  assign beat_o = beat_q;

endmodule

`default_nettype wire

### src/chbd_parser.sv
// ----------------------------------------------------------------------------
// chbd_parser
// Chunk framing state and the per-byte decode: size line, data, trailer and
// end of message, plus the chunk and length counters.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_parser #(
  parameter int unsigned SIZE_BITS   = chbd_pkg::SIZE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = chbd_pkg::LENGTH_BITS_DEF,
  parameter int unsigned COUNT_BITS  = chbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire chbd_pkg::in_beat_t beat_i,
  output chbd_pkg::result_t       result_o
);

  localparam int unsigned CntKeep =
    (COUNT_BITS < chbd_pkg::CHUNK_COUNT_W) ? COUNT_BITS : chbd_pkg::CHUNK_COUNT_W;
  localparam int unsigned LenKeep =
    (LENGTH_BITS < chbd_pkg::BODY_LENGTH_W) ? LENGTH_BITS : chbd_pkg::BODY_LENGTH_W;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_DIGITS = 4'd1,
    PH_REST   = 4'd2,
    PH_DATA   = 4'd3,
    PH_SKIP1  = 4'd4,
    PH_SKIP2  = 4'd5,
    PH_TR0    = 4'd6,
    PH_TR1    = 4'd7,
    PH_TRAIL  = 4'd8,
    PH_DONE   = 4'd9
  } phase_e;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_dec(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  phase_e                 phase_q, phase_d, ph;
  logic [SIZE_BITS-1:0]   acc_q, acc_d, acc;
  logic                   dig_q, dig_d, dig;
  logic                   cr_q, cr_d, cr;
  logic [SIZE_BITS-1:0]   left_q, left_d, left, left_dec;
  logic [2:0]             tm_q, tm_d, tm, tm_step;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, cnt;
  logic [LENGTH_BITS-1:0] tot_q, tot_d, tot;
  logic                   ovf_q, ovf_d, ovf;

  logic [7:0] b;
  logic [4:0] hex;
  logic       is_hex;
  logic [3:0] hval;
  logic       line_end, cr_tail;
  logic [7:0] tr_expect;
  logic [1:0] tr_pos;
  logic       pv, last, bdone, mdone, after;

  assign b      = beat_i.in_byte;
  assign hex    = hex_dec(b);
  assign is_hex = hex[4];
  assign hval   = hex[3:0];

  // state as seen by this byte: restart and unknown phase codes
  always_comb begin
    ph   = phase_q;
    acc  = acc_q;
    dig  = dig_q;
    cr   = cr_q;
    left = left_q;
    tm   = tm_q;
    cnt  = cnt_q;
    tot  = tot_q;
    ovf  = ovf_q;
    if (beat_i.restart) begin
      ph   = PH_LEAD;
      acc  = '0;
      dig  = 1'b0;
      cr   = 1'b0;
      left = '0;
      tm   = '0;
      cnt  = '0;
      tot  = '0;
      ovf  = 1'b0;
    end else if (phase_q > PH_DONE) begin
      ph  = PH_LEAD;
      acc = '0;
      dig = 1'b0;
      cr  = 1'b0;
    end
  end

  // line tail CR LF detection
  assign line_end = (b == chbd_pkg::ChLf) && cr;
  assign cr_tail  = !line_end && (b == chbd_pkg::ChCr);

  // CR LF CR LF matcher step
  assign tr_pos    = tm[1:0];
  assign tr_expect = tr_pos[0] ? chbd_pkg::ChLf : chbd_pkg::ChCr;
  assign tm_step   = (b == tr_expect) ? ({1'b0, tr_pos} + 3'd1)
                                      : ((b == chbd_pkg::ChCr) ? 3'd1 : 3'd0);

  assign left_dec = (left == '0) ? '0 : left - 1'b1;

  // per-byte decode
  always_comb begin
    phase_d = ph;
    acc_d   = acc;
    dig_d   = dig;
    cr_d    = cr;
    left_d  = left;
    tm_d    = tm;
    cnt_d   = cnt;
    tot_d   = tot;
    ovf_d   = ovf;
    pv      = 1'b0;
    last    = 1'b0;
    bdone   = 1'b0;
    mdone   = 1'b0;
    after   = 1'b0;
    case (ph)
      PH_LEAD, PH_DIGITS, PH_REST: begin
        if (ph != PH_REST && is_hex) begin
          // accumulate a digit, saturate on overflow
          if (|acc[SIZE_BITS-1 -: 4]) begin
            acc_d = '1;
            ovf_d = 1'b1;
          end else begin
            acc_d = {acc[SIZE_BITS-5:0], hval};
          end
          dig_d   = 1'b1;
          phase_d = PH_DIGITS;
        end else if (ph == PH_LEAD && (b == chbd_pkg::ChSp || b == chbd_pkg::ChTab)) begin
          phase_d = PH_LEAD;
        end else begin
          phase_d = PH_REST;
          cr_d    = cr_tail;
          if (line_end) begin
            // size line complete
            if (cnt != '1) begin
              cnt_d = cnt + 1'b1;
            end
            if (dig && acc != '0) begin
              left_d  = acc;
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_TR0;
              tm_d    = '0;
              bdone   = 1'b1;
            end
            acc_d = '0;
            dig_d = 1'b0;
          end
        end
      end
      PH_DATA: begin
        pv = 1'b1;
        if (tot != '1) begin
          tot_d = tot + 1'b1;
        end
        left_d = left_dec;
        if (left_dec == '0) begin
          last    = 1'b1;
          phase_d = PH_SKIP1;
        end
      end
      PH_SKIP1: begin
        phase_d = PH_SKIP2;
      end
      PH_SKIP2: begin
        phase_d = PH_LEAD;
        cr_d    = 1'b0;
      end
      PH_TR0: begin
        bdone   = 1'b1;
        tm_d    = (b == chbd_pkg::ChCr) ? 3'd1 : 3'd0;
        phase_d = (b == chbd_pkg::ChCr) ? PH_TR1 : PH_TRAIL;
      end
      PH_TR1: begin
        bdone = 1'b1;
        if (b == chbd_pkg::ChLf) begin
          mdone   = 1'b1;
          tm_d    = '0;
          phase_d = PH_DONE;
        end else begin
          tm_d    = tm_step;
          phase_d = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        bdone = 1'b1;
        tm_d  = tm_step;
        if (tm_step == 3'd4) begin
          mdone   = 1'b1;
          tm_d    = '0;
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
        bdone = 1'b1;
        after = 1'b1;
      end
      default: begin
        phase_d = PH_LEAD;
      end
    endcase
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      acc_q   <= '0;
      dig_q   <= 1'b0;
      cr_q    <= 1'b0;
      left_q  <= '0;
      tm_q    <= '0;
      cnt_q   <= '0;
      tot_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      dig_q   <= dig_d;
      cr_q    <= cr_d;
      left_q  <= left_d;
      tm_q    <= tm_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      ovf_q   <= ovf_d;
    end
  end

  // result fields
  always_comb begin
    result_o               = '0;
    result_o.payload_valid = pv;
    result_o.payload_byte  = pv ? b : 8'h00;
    result_o.chunk_last    = last;
    result_o.body_done     = bdone;
    result_o.message_done  = mdone;
    result_o.after_end     = after;
    result_o.size_error    = ovf_d;
    result_o.chunk_count[CntKeep-1:0] = cnt_d[CntKeep-1:0];
    result_o.body_length[LenKeep-1:0] = tot_d[LenKeep-1:0];
  end

endmodule

`default_nettype wire

### src/chbd_out_stage.sv
// ----------------------------------------------------------------------------
// chbd_out_stage
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire chbd_pkg::result_t result_i,
  output logic                   free_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output chbd_pkg::result_t      result_o
);

  logic              vld_q;
  chbd_pkg::result_t res_q;

  // free when empty or the held beat leaves this cycle
  assign free_o = !vld_q || out_ready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

### src/http_chunked_body_decoder.sv
// Path: input register, combinational decode, then result register.
// Throughput: one byte per cycle unless out_ready_i stalls, set by the
//   combinational decode between the two registers; the input register
//   holds one more byte while a result waits.
// Reset: rst_ni clears all parser state and both stages, no clearing pass.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Chunked transfer body decoder, one byte per beat, one result per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS   = chbd_pkg::SIZE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = chbd_pkg::LENGTH_BITS_DEF,
  parameter int unsigned COUNT_BITS  = chbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             payload_valid_o,
  output logic [7:0]       payload_byte_o,
  output logic             chunk_last_o,
  output logic             body_done_o,
  output logic             message_done_o,
  output logic             after_end_o,
  output logic             size_error_o,
  output logic [31:0]      chunk_count_o,
  output logic [47:0]      body_length_o
);

  chbd_pkg::in_beat_t in_beat, held_beat;
  chbd_pkg::result_t  dec_res, out_res;
  logic               held_vld, out_free, step;

  assign in_beat.in_byte = in_byte_i;
  assign in_beat.restart = restart_i;

  // a held byte is decoded when the result register can take it
  assign step = held_vld && out_free;

  // input register
  chbd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .beat_i     (in_beat),
    .vld_o      (held_vld),
    .take_i     (out_free),
    .beat_o     (held_beat)
  );

  // framing state and decode
  chbd_parser #(
    .SIZE_BITS   (SIZE_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .beat_i   (held_beat),
    .result_o (dec_res)
  );

  // result register
  chbd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (held_vld),
    .result_i    (dec_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign payload_valid_o = out_res.payload_valid;
  assign payload_byte_o  = out_res.payload_byte;
  assign chunk_last_o    = out_res.chunk_last;
  assign body_done_o     = out_res.body_done;
  assign message_done_o  = out_res.message_done;
  assign after_end_o     = out_res.after_end;
  assign size_error_o    = out_res.size_error;
  assign chunk_count_o   = out_res.chunk_count;
  assign body_length_o   = out_res.body_length;

endmodule

`default_nettype wire

### src/chbd_checker.sv
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks on the decoder's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chbd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        payload_valid_o,
  input wire logic [7:0]  payload_byte_o,
  input wire logic        chunk_last_o,
  input wire logic        body_done_o,
  input wire logic        message_done_o,
  input wire logic        after_end_o,
  input wire logic        size_error_o,
  input wire logic [31:0] chunk_count_o,
  input wire logic [47:0] body_length_o
);

  // a non-payload beat carries a zero byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'h00)
    else $error("payload byte not zero on a non-payload beat");

  // chunk end only on a data byte
  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chunk_last_o |-> payload_valid_o && !body_done_o)
    else $error("chunk end flagged on a non-data beat");

  // message end and overrun beats lie past the body
  a_done_in_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (message_done_o || after_end_o) |->
      body_done_o && !payload_valid_o && !(message_done_o && after_end_o))
    else $error("message end flags inconsistent");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(body_length_o) && $stable(chunk_count_o)
      && $stable(size_error_o))
    else $error("result beat changed while stalled");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);

`default_nettype wire

### sim/tb_http_chunked_body_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder. A short table of directed
// beats, with some results typed in, is followed by random chunked messages
// and noise. Every accepted byte runs through a local decode model, and each
// result beat is compared field by field. Sender gaps and receiver stalls
// change from phase to phase, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module tb_http_chunked_body_decoder;

  localparam int unsigned RandomBeats = 850;
  localparam int unsigned HoldCycles  = 48;

  // character codes from the package
  localparam logic [7:0] ChCr  = chbd_pkg::ChCr;
  localparam logic [7:0] ChLf  = chbd_pkg::ChLf;
  localparam logic [7:0] ChSp  = chbd_pkg::ChSp;
  localparam logic [7:0] ChTab = chbd_pkg::ChTab;

  typedef chbd_pkg::result_t result_t;

  // parse phases of the local decode model
  typedef enum logic [3:0] {
    PhLead, PhDigits, PhRest, PhData, PhSkip1, PhSkip2,
    PhTr0, PhTr1, PhTrail, PhDone
  } parse_phase_e;

  // one row of stimulus, optionally with a typed-in result
  typedef struct {
    logic [7:0] chr;
    logic       rst;
    bit         typed;
    result_t    res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        restart_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        payload_valid_o;
  logic [7:0]  payload_byte_o;
  logic        chunk_last_o;
  logic        body_done_o;
  logic        message_done_o;
  logic        after_end_o;
  logic        size_error_o;
  logic [31:0] chunk_count_o;
  logic [47:0] body_length_o;

  stim_row_t   rows[$];
  result_t     pending_results[$];
  int          n_directed;
  int          n_random;
  int          next_idx = 0;
  int          cur_idx = 0;
  logic        next_rst = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_done = 1'b0;
  result_t     predicted;
  result_t     want;

  // decode model state
  parse_phase_e ph = PhLead;
  logic [31:0]  size_acc = '0;
  logic         dig_seen = 1'b0;
  logic         cr_seen = 1'b0;
  logic [31:0]  left_cnt = '0;
  logic [2:0]   crlf_match = '0;
  logic [31:0]  n_chunks = '0;
  logic [47:0]  n_payload = '0;
  logic         ovf = 1'b0;

  http_chunked_body_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_valid_o(payload_valid_o),
    .payload_byte_o (payload_byte_o),
    .chunk_last_o   (chunk_last_o),
    .body_done_o    (body_done_o),
    .message_done_o (message_done_o),
    .after_end_o    (after_end_o),
    .size_error_o   (size_error_o),
    .chunk_count_o  (chunk_count_o),
    .body_length_o  (body_length_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decode model
  // ---------------------------------------------------------------------------

  // CR directly followed by LF ends a size line
  function automatic bit line_ends(input logic [7:0] b);
    if (b == ChLf && cr_seen) begin
      cr_seen = 1'b0;
      return 1'b1;
    end
    cr_seen = (b == ChCr);
    return 1'b0;
  endfunction

  // close a size line; returns 1 for the last chunk
  function automatic bit end_of_size_line();
    bit zero_size;
    if (n_chunks != '1) n_chunks++;
    zero_size = !(dig_seen && size_acc != '0);
    if (zero_size) begin
      ph = PhTr0;
      crlf_match = '0;
    end else begin
      left_cnt = size_acc;
      ph = PhData;
    end
    size_acc = '0;
    dig_seen = 1'b0;
    return zero_size;
  endfunction

  // CR LF CR LF matcher; returns 1 when complete
  function automatic bit crlf_step(input logic [7:0] b);
    logic [2:0] m;
    m = {1'b0, crlf_match[1:0]};
    if (b == (m[0] ? ChLf : ChCr)) m = m + 3'd1;
    else m = (b == ChCr) ? 3'd1 : 3'd0;
    crlf_match = m;
    return m == 3'd4;
  endfunction

  function automatic result_t chunk_decode(input logic [7:0] b, input logic rst);
    result_t    r;
    logic       is_hex;
    logic [3:0] nib;
    r = '0;
    if (rst) begin
      ph = PhLead;
      size_acc = '0;
      dig_seen = 1'b0;
      cr_seen = 1'b0;
      left_cnt = '0;
      crlf_match = '0;
      n_chunks = '0;
      n_payload = '0;
      ovf = 1'b0;
    end
    is_hex = 1'b1;
    nib = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) nib = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) nib = 4'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) nib = 4'(b - 8'h37);
    else is_hex = 1'b0;

    case (ph)
      PhLead, PhDigits: begin
        if (is_hex) begin
          // saturate on a digit that no longer fits
          if (size_acc > 32'h0FFF_FFFF) begin
            size_acc = '1;
            ovf = 1'b1;
          end else begin
            size_acc = {size_acc[27:0], nib};
          end
          dig_seen = 1'b1;
          ph = PhDigits;
        end else if (!(ph == PhLead && (b == ChSp || b == ChTab))) begin
          ph = PhRest;
          if (line_ends(b)) r.body_done = end_of_size_line();
        end
      end
      PhRest: begin
        if (line_ends(b)) r.body_done = end_of_size_line();
      end
      PhData: begin
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        if (n_payload != '1) n_payload++;
        if (left_cnt != '0) left_cnt--;
        if (left_cnt == '0) begin
          r.chunk_last = 1'b1;
          ph = PhSkip1;
        end
      end
      PhSkip1: ph = PhSkip2;
      PhSkip2: begin
        ph = PhLead;
        cr_seen = 1'b0;
      end
      PhTr0: begin
        r.body_done = 1'b1;
        crlf_match = '0;
        void'(crlf_step(b));
        ph = (b == ChCr) ? PhTr1 : PhTrail;
      end
      PhTr1: begin
        r.body_done = 1'b1;
        if (b == ChLf) begin
          r.message_done = 1'b1;
          crlf_match = '0;
          ph = PhDone;
        end else begin
          void'(crlf_step(b));
          ph = PhTrail;
        end
      end
      PhTrail: begin
        r.body_done = 1'b1;
        if (crlf_step(b)) begin
          r.message_done = 1'b1;
          crlf_match = '0;
          ph = PhDone;
        end
      end
      PhDone: begin
        r.body_done = 1'b1;
        r.after_end = 1'b1;
      end
      default: ph = PhLead;
    endcase

    r.size_error = ovf;
    r.chunk_count = n_chunks;
    r.body_length = n_payload;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus build
  // ---------------------------------------------------------------------------

  function automatic result_t mk_res(input logic pv, input logic [7:0] pb, input logic cl,
                                     input logic bd, input logic md, input logic ae,
                                     input logic se, input logic [31:0] cc,
                                     input logic [47:0] bl);
    result_t r;
    r.payload_valid = pv;
    r.payload_byte = pb;
    r.chunk_last = cl;
    r.body_done = bd;
    r.message_done = md;
    r.after_end = ae;
    r.size_error = se;
    r.chunk_count = cc;
    r.body_length = bl;
    return r;
  endfunction

  task automatic put(input logic [7:0] c, input logic r);
    stim_row_t s;
    s.chr = c;
    s.rst = r;
    s.typed = 1'b0;
    s.res = '0;
    rows.push_back(s);
  endtask

  task automatic put_exp(input logic [7:0] c, input logic r, input result_t res);
    stim_row_t s;
    s.chr = c;
    s.rst = r;
    s.typed = 1'b1;
    s.res = res;
    rows.push_back(s);
  endtask

  // restart rides on the first byte after it is requested
  task automatic emit(input logic [7:0] c);
    put(c, next_rst);
    next_rst = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  task automatic gen_size_line(input logic [31:0] size, input bit no_digits);
    int top;
    int k;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
      emit($urandom_range(1) ? ChSp : ChTab);
    if (!no_digits) begin
      if ($urandom_range(7) == 0) emit(8'h30);
      top = 7;
      while (top > 0 && size[4*top +: 4] == 4'h0) top--;
      for (k = top; k >= 0; k--) emit(hex_char(size[4*k +: 4]));
    end
    // chunk extension, ignored up to the line end
    if ($urandom_range(4) == 0) begin
      emit(8'h3b);
      repeat ($urandom_range(1, 5)) emit(8'($urandom_range(8'h61, 8'h7a)));
    end
    emit(ChCr);
    emit(ChLf);
  endtask

  // message with random content; a chunk's CR LF is now and then two random bytes
  task automatic gen_message();
    int sz;
    next_rst = 1'b1;
    repeat ($urandom_range(0, 3)) begin
      sz = ($urandom_range(19) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 12);
      gen_size_line(32'(sz), 1'b0);
      repeat (sz) emit(8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        emit(8'($urandom_range(255)));
        emit(8'($urandom_range(255)));
      end else begin
        emit(ChCr);
        emit(ChLf);
      end
    end
    gen_size_line('0, $urandom_range(3) == 0);
    if ($urandom_range(1)) begin
      emit(ChCr);
      emit(ChLf);
    end else begin
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(1, 6))
          emit(($urandom_range(7) == 0) ? ChCr : 8'($urandom_range(8'h41, 8'h7a)));
        emit(ChCr);
        emit(ChLf);
      end
      emit(ChCr);
      emit(ChLf);
    end
    repeat ($urandom_range(0, 3)) emit(8'($urandom_range(255)));
  endtask

  // noise and broken sequences
  task automatic gen_noise();
    logic [7:0] c;
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(1, 12)) begin
          next_rst = ($urandom_range(9) == 0);
          emit(8'($urandom_range(255)));
        end
      end
      1: begin
        // size wider than the accumulator
        next_rst = 1'b1;
        emit(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 10)) emit(hex_char(4'($urandom_range(15))));
        emit(ChCr);
        emit(ChLf);
        repeat ($urandom_range(1, 4)) emit(8'($urandom_range(255)));
      end
      2: begin
        // sign or 0x prefix, then a bare LF before the real line end
        next_rst = 1'b1;
        case ($urandom_range(2))
          0: emit(8'h2b);
          1: emit(8'h2d);
          default: begin
            emit(8'h30);
            emit(8'h78);
          end
        endcase
        emit(hex_char(4'($urandom_range(15))));
        emit(ChLf);
        emit(ChCr);
        emit(ChLf);
        repeat ($urandom_range(1, 4)) emit(8'($urandom_range(255)));
      end
      default: begin
        // line-end heavy garbage
        next_rst = 1'b1;
        repeat ($urandom_range(4, 16)) begin
          case ($urandom_range(5))
            0: c = ChCr;
            1: c = ChLf;
            2: c = 8'h30;
            3: c = 8'h61;
            4: c = ChSp;
            default: c = 8'($urandom_range(255));
          endcase
          emit(c);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // idle control
  // ---------------------------------------------------------------------------

  function automatic int unsigned phase_of(input int idx);
    if (idx < n_directed) return 0;
    return ((idx - n_directed) * 4) / n_random;
  endfunction

  // ---------------------------------------------------------------------------
  // sender and input beat tracking
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // accepted byte: work out its result beat
      if (in_valid_i && in_ready_o) begin
        predicted = chunk_decode(in_byte_i, restart_i);
        pending_results.push_back(rows[cur_idx].typed ? rows[cur_idx].res : predicted);
      end
      // offer the next byte or idle
      if (!in_valid_i || in_ready_o) begin
        if (next_idx < rows.size() &&
            $urandom_range(99) >= ((phase_of(next_idx) == 1) ? 60 :
                                   (phase_of(next_idx) == 3) ? 11 : 0)) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= rows[next_idx].chr;
          restart_i  <= rows[next_idx].rst;
          cur_idx    <= next_idx;
          next_idx   <= next_idx + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt    <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && next_idx >= n_directed + n_random / 8) begin
        hold_cnt    <= HoldCycles;
        hold_done   <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= $urandom_range(99) >= ((phase_of(next_idx) == 2) ? 60 :
                                              (phase_of(next_idx) == 3) ? 11 : 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("payload_valid", 64'(want.payload_valid), 64'(payload_valid_o));
        check_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte_o));
        check_field("chunk_last", 64'(want.chunk_last), 64'(chunk_last_o));
        check_field("body_done", 64'(want.body_done), 64'(body_done_o));
        check_field("message_done", 64'(want.message_done), 64'(message_done_o));
        check_field("after_end", 64'(want.after_end), 64'(after_end_o));
        check_field("size_error", 64'(want.size_error), 64'(size_error_o));
        check_field("chunk_count", 64'(want.chunk_count), 64'(chunk_count_o));
        check_field("body_length", 64'(want.body_length), 64'(body_length_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // directed table: chr, restart, typed result where obvious
    // skipped lead
    put_exp(ChTab, 1'b1,
            mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 48'd0));
    put(8'h32, 1'b0);                                             // size 2
    put(ChLf, 1'b0);                                              // bare lf
    put(ChCr, 1'b0);
    put_exp(ChLf, 1'b0,
            mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1, 48'd0));
    put_exp(8'hff, 1'b0,
            mk_res(1'b1, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1, 48'd1));
    put_exp(8'h00, 1'b0,
            mk_res(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 32'd1, 48'd2));
    put(ChCr, 1'b0);                                              // dropped
    put(ChLf, 1'b0);
    put(8'h30, 1'b0);                                             // 0x prefix
    put(8'h78, 1'b0);
    put(ChCr, 1'b0);
    put_exp(ChLf, 1'b0,
            mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd2, 48'd2));
    put(8'h54, 1'b0);                                             // trailer line
    put(ChCr, 1'b0);
    put(ChLf, 1'b0);
    put(ChCr, 1'b0);
    put_exp(ChLf, 1'b0,
            mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 32'd2, 48'd2));
    put_exp(8'hff, 1'b0,
            mk_res(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 32'd2, 48'd2));
    put(8'h31, 1'b1);                                             // oversized size
    repeat (7) put(8'h66, 1'b0);
    put_exp(8'h46, 1'b0,
            mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 48'd0));
    n_directed = rows.size();

    // random part, opened by a message so the oversized size is cleared
    gen_message();
    while (rows.size() - n_directed < RandomBeats) begin
      if ($urandom_range(4) == 0) gen_noise();
      else gen_message();
    end
    n_random = rows.size() - n_directed;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (next_idx < rows.size() || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
src/chbd_pkg.sv
src/chbd_in_stage.sv
src/chbd_parser.sv
src/chbd_out_stage.sv
src/http_chunked_body_decoder.sv
src/chbd_checker.sv
sim/tb_http_chunked_body_decoder.sv
